// ===== design/tdq_pkg.sv =====
// tdq_pkg: shared word types, operation codes and status codes for task_deque.
// No dependencies.
package tdq_pkg;

    localparam int OP_W       = 3;
    localparam int RUN_TIME_W = 8;
    localparam int STATUS_W   = 2;
    localparam int NUMBER_W   = 16;
    localparam int COUNT_W    = 5;

    localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd2;
    localparam logic [OP_W-1:0] OP_DRAIN_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN_BACK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [RUN_TIME_W-1:0] run_time;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [NUMBER_W-1:0]   task_number;
        logic [RUN_TIME_W-1:0] task_time;
        logic [NUMBER_W-1:0]   front_number;
        logic [RUN_TIME_W-1:0] front_time;
        logic [NUMBER_W-1:0]   back_number;
        logic [RUN_TIME_W-1:0] back_time;
        logic [COUNT_W-1:0]    entry_count;
        logic                  last_of_run;
    } rsp_word_t;

endpackage

// ===== design/tdq_ram.sv =====
// tdq_ram: task storage, one write port and one read port, registered read data.
// No dependencies.
module tdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/task_deque.sv =====
// task_deque: bounded double-ended task queue with push, pop and drain.
// Depends on tdq_pkg and tdq_ram.
//
//  channel  direction  word        handshake
//  req      in         req_word_t  req_valid / req_ready
//  rsp      out        rsp_word_t  rsp_valid / rsp_ready
//
// Push and pop: accepted in S_IDLE, then executed in S_EXEC with the memory read back.
// Drain: accepted in S_IDLE, then one rsp word per held task from S_EXEC; one read of the single read port per task.
// Reset leaves the queue empty; storage needs no clearing pass.
// A held rsp word stalls execution; req_ready is high only when no word is in work.
module task_deque
    import tdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    typedef struct packed {
        logic [NUMBER_W-1:0]   number;
        logic [TIME_WIDTH-1:0] run;
    } entry_t;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    entry_t    front_reg, front_next;
    entry_t    back_reg, back_next;
    req_word_t op_reg, op_next;
    logic      rsp_valid_reg;
    rsp_word_t rsp_reg, rsp_next;

    logic      out_free;
    logic      fire;
    logic      last;
    logic      is_drain;
    logic      wr_en;
    logic [IW-1:0] wr_addr;
    entry_t    wr_data;
    logic      rd_en;
    logic [IW-1:0] rd_addr;
    entry_t    rd_data;
    logic [OP_W-1:0] rd_op;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] back_sum;
    logic [IW-1:0] tail_addr;
    logic [IW-1:0] front_addr;
    logic [IW-1:0] back_addr;
    logic [TIME_WIDTH+RUN_TIME_W-1:0] wr_time_ext;
    logic [CW+COUNT_W-1:0] count_ext;
    entry_t    taken;

    function automatic logic [RUN_TIME_W-1:0] to_out_time(input logic [TIME_WIDTH-1:0] t);
        logic [TIME_WIDTH+RUN_TIME_W-1:0] e;
        e = {{RUN_TIME_W{1'b0}}, t};
        return e[RUN_TIME_W-1:0];
    endfunction

    tdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (NUMBER_W + TIME_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign is_drain  = (op_reg.operation == OP_DRAIN_FRONT)
                    || (op_reg.operation == OP_DRAIN_BACK);

    // tail slot for a push
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
    assign wr_time_ext = {{TIME_WIDTH{1'b0}}, op_reg.run_time};

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        front_next = front_reg;
        back_next  = back_reg;
        op_next    = op_reg;
        rsp_next   = rsp_reg;
        fire       = 1'b0;
        last       = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = tail_addr;
        wr_data.number = (count_reg == '0) ? NUMBER_W'(1) : back_reg.number + NUMBER_W'(1);
        wr_data.run    = wr_time_ext[TIME_WIDTH-1:0];
        taken      = '0;
        rsp_next.status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    fire = 1'b1;
                    case (op_reg.operation) inside
                        OP_PUSH_BACK:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                taken      = wr_data;
                                back_next  = wr_data;
                                if (count_reg == '0)
                                begin
                                    front_next = wr_data;
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT, OP_DRAIN_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                taken      = front_reg;
                                front_next = rd_data;
                                head_next  = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
                                count_next = count_reg - CW'(1);
                                last       = (count_next == '0);
                            end
                        end
                        OP_POP_BACK, OP_DRAIN_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                taken      = back_reg;
                                back_next  = rd_data;
                                count_next = count_reg - CW'(1);
                                last       = (count_next == '0);
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (!is_drain)
                    begin
                        last = 1'b1;
                    end
                    if (is_drain && last && count_reg != '0)
                    begin
                        head_next = '0;
                    end
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_ext = {{COUNT_W{1'b0}}, count_next};
        rsp_next.task_number  = taken.number;
        rsp_next.task_time    = to_out_time(taken.run);
        rsp_next.front_number = (count_next == '0) ? '0 : front_next.number;
        rsp_next.front_time   = (count_next == '0) ? '0 : to_out_time(front_next.run);
        rsp_next.back_number  = (count_next == '0) ? '0 : back_next.number;
        rsp_next.back_time    = (count_next == '0) ? '0 : to_out_time(back_next.run);
        rsp_next.entry_count  = count_ext[COUNT_W-1:0];
        rsp_next.last_of_run  = last;
    end

    // read the entry that becomes the new front or back after the next removal
    assign rd_op    = (state_reg == S_IDLE) ? req.operation : op_reg.operation;
    assign rd_en    = ((state_reg == S_IDLE) && req_valid) || fire;
    assign back_sum = SW'(head_next) + SW'(count_next) - SW'(2);
    assign front_addr = (head_next == IW'(DEPTH - 1)) ? '0 : head_next + IW'(1);
    assign back_addr  = (count_next < CW'(2)) ? head_next
                      : (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH))
                      : IW'(back_sum);
    assign rd_addr  = ((rd_op == OP_POP_FRONT) || (rd_op == OP_DRAIN_FRONT))
                    ? front_addr : back_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        op_reg    <= op_next;
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("held count above depth");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_drain) |=> (state_reg == S_IDLE))
        else $error("single-result operation did not finish");

    a_drain_more: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last) |=> (state_reg == S_EXEC))
        else $error("drain stopped before last word");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_drain && last && (count_reg != '0))
        |=> (count_reg == '0) && (head_reg == '0))
        else $error("drain left tasks behind");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (op_reg.operation == OP_PUSH_BACK) && (count_reg != CW'(DEPTH)))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not add a task");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for task_deque; runs directed deque cases and random
// push/pop/drain traffic under idling and backpressure against a predictor.
// Depends on tdq_pkg and design/task_deque.sv.
module tb_top;
    import tdq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_REPORTS  = 30;
    localparam int PHASE_WORDS  = 100;

    // codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp;

    task_deque #(
        .DEPTH      (QDEPTH),
        .TIME_WIDTH (RUN_TIME_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted deque contents
    logic [NUMBER_W-1:0]   slot_number [QDEPTH];
    logic [RUN_TIME_W-1:0] slot_time   [QDEPTH];
    int                    head_slot = 0;
    int                    held      = 0;

    rsp_word_t due_words[$];
    int        errors      = 0;
    int        rsp_seen    = 0;
    int        send_idle   = 0;
    int        recv_stall  = 0;
    int        hold_req    = 0;
    int        hold_seen   = 0;
    int        hold_cnt    = 0;
    int        quiet_cycles = 0;

    task report(input string what, input logic [15:0] got, input logic [15:0] want);
        if (errors < MAX_REPORTS)
            $display("mismatch %s at word %0d: got %h want %h", what, rsp_seen, got, want);
        errors = errors + 1;
    endtask

    function void expect_word(input logic [STATUS_W-1:0] st, input logic [NUMBER_W-1:0] num,
                              input logic [RUN_TIME_W-1:0] tim, input logic last);
        rsp_word_t w;
        w = '0;
        w.status      = st;
        w.task_number = num;
        w.task_time   = tim;
        if (held > 0)
        begin
            w.front_number = slot_number[head_slot];
            w.front_time   = slot_time[head_slot];
            w.back_number  = slot_number[(head_slot + held - 1) % QDEPTH];
            w.back_time    = slot_time[(head_slot + held - 1) % QDEPTH];
        end
        w.entry_count = held[COUNT_W-1:0];
        w.last_of_run = last;
        due_words.push_back(w);
    endfunction

    function void take_task(input logic from_front, output logic [NUMBER_W-1:0] num,
                            output logic [RUN_TIME_W-1:0] tim);
        int s;
        s = from_front ? head_slot : (head_slot + held - 1) % QDEPTH;
        num = slot_number[s];
        tim = slot_time[s];
        if (from_front)
            head_slot = (head_slot + 1) % QDEPTH;
        held = held - 1;
    endfunction

    function void apply_deque_op(input req_word_t w);
        logic [NUMBER_W-1:0]   num;
        logic [RUN_TIME_W-1:0] tim;
        case (w.operation)
            OP_PUSH_BACK:
            begin
                if (held == QDEPTH)
                    expect_word(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    num = (held == 0) ? 16'd1 : slot_number[(head_slot + held - 1) % QDEPTH] + 16'd1;
                    slot_number[(head_slot + held) % QDEPTH] = num;
                    slot_time[(head_slot + held) % QDEPTH]   = w.run_time;
                    held = held + 1;
                    expect_word(ST_OK, num, w.run_time, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (held == 0)
                    expect_word(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    take_task(w.operation == OP_POP_FRONT, num, tim);
                    expect_word(ST_OK, num, tim, 1'b1);
                end
            end
            OP_DRAIN_FRONT, OP_DRAIN_BACK:
            begin
                if (held == 0)
                    expect_word(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    while (held > 0)
                    begin
                        take_task(w.operation == OP_DRAIN_FRONT, num, tim);
                        expect_word(ST_OK, num, tim, held == 0);
                    end
                    head_slot = 0;
                end
            end
            default:
                expect_word(ST_OK, '0, '0, 1'b1);
        endcase
    endfunction

    function req_word_t make_word(input logic [OP_W-1:0] op, input logic [RUN_TIME_W-1:0] rt);
        req_word_t w;
        w.operation = op;
        w.run_time  = rt;
        return w;
    endfunction

    function logic [RUN_TIME_W-1:0] rand_time();
        return RUN_TIME_W'($urandom_range(255));
    endfunction

    // valid stays high between back-to-back words; a gap lowers it at the accepting edge
    task send_word(input req_word_t w);
        if (req_valid && $urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        apply_deque_op(w);
    endtask

    task wait_all_results;
        req_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_words.size() == 0)
                report("no word due, task_number", rsp.task_number, 16'h0);
            else
            begin
                want = due_words.pop_front();
                if (rsp.status !== want.status)
                    report("status", 16'(rsp.status), 16'(want.status));
                if (rsp.task_number !== want.task_number)
                    report("task_number", rsp.task_number, want.task_number);
                if (rsp.task_time !== want.task_time)
                    report("task_time", 16'(rsp.task_time), 16'(want.task_time));
                if (rsp.front_number !== want.front_number)
                    report("front_number", rsp.front_number, want.front_number);
                if (rsp.front_time !== want.front_time)
                    report("front_time", 16'(rsp.front_time), 16'(want.front_time));
                if (rsp.back_number !== want.back_number)
                    report("back_number", rsp.back_number, want.back_number);
                if (rsp.back_time !== want.back_time)
                    report("back_time", 16'(rsp.back_time), 16'(want.back_time));
                if (rsp.entry_count !== want.entry_count)
                    report("entry_count", 16'(rsp.entry_count), 16'(want.entry_count));
                if (rsp.last_of_run !== want.last_of_run)
                    report("last_of_run", 16'(rsp.last_of_run), 16'(want.last_of_run));
            end
            rsp_seen <= rsp_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task test_empty_queue;
        send_word(make_word(OP_POP_FRONT, 8'hFF));
        send_word(make_word(OP_POP_BACK, 8'h00));
        send_word(make_word(OP_DRAIN_FRONT, 8'hA5));
        send_word(make_word(OP_DRAIN_BACK, 8'h5A));
        send_word(make_word(OP_SPARE_A, 8'h00));
        send_word(make_word(OP_SPARE_B, 8'hFF));
        wait_all_results();
    endtask

    task test_fill_to_full;
        send_word(make_word(OP_PUSH_BACK, 8'h00));
        send_word(make_word(OP_PUSH_BACK, 8'hFF));
        for (int i = 2; i < QDEPTH; i++)
            send_word(make_word(OP_PUSH_BACK, rand_time()));
        send_word(make_word(OP_SPARE_C, 8'h00));
        send_word(make_word(OP_PUSH_BACK, 8'h77));
        send_word(make_word(OP_DRAIN_BACK, 8'h00));
        wait_all_results();
    endtask

    task test_single_task;
        send_word(make_word(OP_PUSH_BACK, 8'h12));
        send_word(make_word(OP_POP_FRONT, 8'h00));
        send_word(make_word(OP_PUSH_BACK, 8'h34));
        send_word(make_word(OP_POP_BACK, 8'h00));
        send_word(make_word(OP_PUSH_BACK, 8'h56));
        send_word(make_word(OP_DRAIN_FRONT, 8'h00));
        send_word(make_word(OP_PUSH_BACK, 8'h78));
        send_word(make_word(OP_DRAIN_BACK, 8'h00));
        wait_all_results();
    endtask

    task test_backpressure;
        send_idle = 0;
        hold_req = hold_req + 1;
        for (int i = 0; i < 30; i++)
            send_word(make_word((i % 5 == 4) ? OP_POP_FRONT : OP_PUSH_BACK, rand_time()));
        send_word(make_word(OP_DRAIN_FRONT, 8'h00));
        wait_all_results();
    endtask

    task run_phase(input int idle_pct, input int stall_pct);
        int                bias;
        int                r;
        logic [OP_W-1:0]   op;
        send_idle = idle_pct;
        recv_stall <= stall_pct;
        bias = 0;
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            if (i % 16 == 0)
                bias = $urandom_range(2);
            r = $urandom_range(99);
            if (r < ((bias == 0) ? 75 : (bias == 1) ? 30 : 50))
                op = OP_PUSH_BACK;
            else if (r < ((bias == 0) ? 90 : (bias == 1) ? 80 : 85))
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
            else if (r < ((bias == 0) ? 95 : (bias == 1) ? 90 : 93))
                op = $urandom_range(1) ? OP_DRAIN_FRONT : OP_DRAIN_BACK;
            else
                op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
            send_word(make_word(op, rand_time()));
        end
        wait_all_results();
    endtask

    task test_random_traffic;
        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(15, 15);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_to_full();
        test_single_task();
        test_backpressure();
        test_random_traffic();
        wait_all_results();
        repeat (2 * QDEPTH + 8) @(posedge clk);
        if (errors == 0 && due_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
